@@ rtl/linear_interp_pitch_resampler_defines.svh @@
// assertion macros for the pitch resampler
`ifndef LINEAR_INTERP_PITCH_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_PITCH_RESAMPLER_DEFINES_SVH

// same-cycle implication, checked on clk outside of rst
`define LIPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk outside of rst
`define LIPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lipr_pkg.sv @@
// shared constants and types of the pitch resampler
package lipr_pkg;

  localparam int INC_BITS  = 19;
  localparam int FRAC_BITS = 16;
  localparam int OWED_BITS = INC_BITS - FRAC_BITS;
  localparam int STEP_BITS = $clog2(FRAC_BITS);

  typedef logic [INC_BITS-1:0]  inc_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [OWED_BITS-1:0] owed_t;
  typedef logic [STEP_BITS-1:0] step_t;

  localparam inc_t  INC_MIN   = inc_t'(8192);
  localparam inc_t  INC_MAX   = inc_t'(262144);
  localparam inc_t  INC_RESET = inc_t'(65536);
  localparam owed_t OWED_RESET = owed_t'(1);
  localparam step_t STEP_LAST = step_t'(FRAC_BITS - 1);

endpackage

@@ rtl/lipr_stream_if.sv @@
// input and result channel interfaces of the pitch resampler
interface lipr_stream_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_ch0;
  logic signed [SAMPLE_BITS-1:0] sample_ch1;

  modport source (output valid, output sample_ch0, output sample_ch1, input ready);
  modport sink (input valid, input sample_ch0, input sample_ch1, output ready);
endinterface

interface lipr_result_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_ch0;
  logic signed [SAMPLE_BITS-1:0] out_ch1;
  logic                          last_of_run;

  modport source (output valid, output out_ch0, output out_ch1, output last_of_run,
                  input ready);
  modport sink (input valid, input out_ch0, input out_ch1, input last_of_run,
                output ready);
endinterface

@@ rtl/linear_interp_pitch_resampler.sv @@
// linear interpolation pitch resampler with bit-serial fraction multiply
// an input item that owes no result is taken in the idle state, which then waits for the next item;
// otherwise each result takes a multiply step, the bit-serial multiply by the phase fraction,
// one bit per cycle, then a finish step that waits until the output register is free, writes it and steps the phase
// the first result is valid once the finish step has written the output register
// rst (synchronous) clears samples and phase, sets pitch to unity and owed to one
`include "linear_interp_pitch_resampler_defines.svh"

module linear_interp_pitch_resampler
  import lipr_pkg::*;
#(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [INC_BITS-1:0] wr_data,
  lipr_stream_if.sink         feed,
  lipr_result_if.source       result
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  inc_t       pitch;
  inc_t       inc_used;
  inc_t       acc;
  frac_t      phase;
  frac_t      mult_bits;
  owed_t      owed;
  owed_t      owed_dec;
  step_t      step;
  logic       run_last;
  logic       out_free;
  logic       out_valid;
  logic       out_last;

  logic signed [SAMPLE_BITS-1:0] in_samp  [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] older    [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] newer    [CHANNELS];
  logic signed [SAMPLE_BITS:0]   diff     [CHANNELS];
  logic signed [SAMPLE_BITS+1:0] prod     [CHANNELS];
  logic signed [SAMPLE_BITS+1:0] prod_sum [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] interp   [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] out_val  [CHANNELS];

  assign in_samp[0] = feed.sample_ch0;

  generate
    if (CHANNELS > 1) begin : g_two
      assign in_samp[1]     = feed.sample_ch1;
      assign result.out_ch1 = out_val[1];
    end else begin : g_one
      assign result.out_ch1 = '0;
    end
  endgenerate

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      prod_sum[c] = prod[c] + (mult_bits[0] ? {diff[c][SAMPLE_BITS], diff[c]} : '0);
      interp[c]   = older[c] + prod[c][SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    if (pitch < INC_MIN) begin
      inc_used = INC_MIN;
    end else if (pitch > INC_MAX) begin
      inc_used = INC_MAX;
    end else begin
      inc_used = pitch;
    end
    acc      = inc_t'(phase) + inc_used;
    run_last = acc[INC_BITS-1:FRAC_BITS] != '0;
    owed_dec = ((owed == '0) ? owed_t'(1) : owed) - owed_t'(1);
    out_free = !out_valid || result.ready;
  end

  assign feed.ready         = (state == S_IDLE);
  assign result.valid       = out_valid;
  assign result.last_of_run = out_last;
  assign result.out_ch0     = out_val[0];

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch <= INC_RESET;
    end else if (wr_en) begin
      pitch <= wr_data;
    end
  end

  // sequencer, phase and owed count
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      owed      <= OWED_RESET;
      out_valid <= 1'b0;
      step      <= '0;
      mult_bits <= '0;
    end else begin
      if (out_valid && result.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (feed.valid) begin
            owed <= owed_dec;
            if (owed_dec == '0) begin
              state     <= S_MUL;
              step      <= '0;
              mult_bits <= phase;
            end
          end
        end
        S_MUL: begin
          mult_bits <= mult_bits >> 1;
          step      <= step + step_t'(1);
          if (step == STEP_LAST) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            phase     <= acc[FRAC_BITS-1:0];
            owed      <= acc[INC_BITS-1:FRAC_BITS];
            if (run_last) begin
              state <= S_IDLE;
            end else begin
              state     <= S_MUL;
              step      <= '0;
              mult_bits <= acc[FRAC_BITS-1:0];
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // sample history
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        older[c] <= '0;
        newer[c] <= '0;
        diff[c]  <= '0;
      end
    end else if (state == S_IDLE && feed.valid) begin
      for (int c = 0; c < CHANNELS; c++) begin
        older[c] <= newer[c];
        newer[c] <= in_samp[c];
        diff[c]  <= {in_samp[c][SAMPLE_BITS-1], in_samp[c]}
                  - {newer[c][SAMPLE_BITS-1], newer[c]};
      end
    end
  end

  // shift-add product lanes and output register
  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (state == S_MUL) begin
        prod[c] <= prod_sum[c] >>> 1;
      end else if (state != S_FIN || out_free) begin
        prod[c] <= '0;
      end
      if (state == S_FIN && out_free) begin
        out_val[c] <= interp[c];
      end
    end
    if (state == S_FIN && out_free) begin
      out_last <= run_last;
    end
  end

  `LIPR_ASSERT_NOW(a_result_from_fin, $rose(out_valid), $past(state) == S_FIN, "result without finish step")
  `LIPR_ASSERT_NOW(a_owed_nonzero_idle, state == S_IDLE, owed != '0, "idle with no sample owed")
  `LIPR_ASSERT_NEXT(a_mul_runs, state == S_MUL && step != STEP_LAST, state == S_MUL, "multiply cut short")
  `LIPR_ASSERT_NEXT(a_last_ends_run, state == S_FIN && out_free && run_last, state == S_IDLE && out_last, "run did not end on last")

endmodule
